FILE: sv/crp_pkg.sv
// Shared types and constants for the cell reference parser.
package crp_pkg;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 17;
  localparam int ROWIX_W = 16;
  localparam int CHAR_W  = 8;
  localparam int CFG_W   = 17;
  // one digit more than the row limit: row * 10 + 9
  localparam int ROWMUL_W = ROW_W + 4;

  localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  localparam logic [COL_W-1:0] ALPHA_COUNT = 10'd26;

  localparam logic [COL_W-1:0] MAX_COLS_RST = 10'd256;
  localparam logic [ROW_W-1:0] MAX_ROWS_RST = 17'd65536;

  // configuration register indexes
  typedef enum logic {
    CFG_MAX_COLS = 1'b0,
    CFG_MAX_ROWS = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_FIRST           = 2'd0,
    PH_LETTER_OR_DIGIT = 2'd1,
    PH_DIGITS          = 2'd2
  } parse_phase_t;

  typedef struct packed {
    parse_phase_t     phase;
    logic [COL_W-1:0] column_acc;
    logic [ROW_W-1:0] row_acc;
    logic             error_seen;
  } parse_state_t;

  typedef struct packed {
    logic               name_ok;
    logic [COL_W-1:0]   column_index;
    logic [ROWIX_W-1:0] row_index;
  } parse_result_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:      PH_FIRST,
    column_acc: '0,
    row_acc:    '0,
    error_seen: 1'b0
  };

endpackage

FILE: sv/crp_step.sv
// Per-character next-state and result logic of the cell reference parser.
module crp_step (
  input  crp_pkg::parse_state_t           cur_state,
  input  logic [crp_pkg::CHAR_W-1:0]      char_code,
  input  logic                            last_char,
  input  logic [crp_pkg::COL_W-1:0]       max_cols,
  input  logic [crp_pkg::ROW_W-1:0]       max_rows,
  output crp_pkg::parse_state_t           state_nxt,
  output crp_pkg::parse_result_t          result
);
  import crp_pkg::*;

  logic                is_upper;
  logic                is_lower;
  logic                is_letter;
  logic                is_digit;
  logic [CHAR_W-1:0]   letter_off;
  logic [COL_W-1:0]    letter_val;
  logic [CHAR_W-1:0]   digit_off;
  logic [ROWMUL_W-1:0] row_next;
  logic [COL_W-1:0]    col_two;
  parse_state_t        upd;

  assign is_upper  = (char_code >= CHAR_UP_A) && (char_code <= CHAR_UP_Z);
  assign is_lower  = (char_code >= CHAR_LO_A) && (char_code <= CHAR_LO_Z);
  assign is_letter = is_upper || is_lower;
  assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);

  assign letter_off = is_lower ? (char_code - CHAR_LO_A) : (char_code - CHAR_UP_A);
  assign letter_val = {{(COL_W-5){1'b0}}, letter_off[4:0]};
  assign digit_off  = char_code - CHAR_ZERO;

  // row * 10 + digit as two shifts and adds
  assign row_next = {1'b0, cur_state.row_acc, 3'b000}
                  + {3'b000, cur_state.row_acc, 1'b0}
                  + {{(ROWMUL_W-4){1'b0}}, digit_off[3:0]};

  // first column is at most 25 here, so this stays below 702
  assign col_two = (cur_state.column_acc + 10'd1) * ALPHA_COUNT + letter_val;

  always_comb begin
    upd = cur_state;
    if (!cur_state.error_seen) begin
      unique case (cur_state.phase)
        PH_FIRST: begin
          if (!is_letter) begin
            upd.error_seen = 1'b1;
          end else begin
            upd.column_acc = letter_val;
            upd.phase      = PH_LETTER_OR_DIGIT;
            upd.error_seen = (letter_val >= max_cols);
          end
        end
        PH_LETTER_OR_DIGIT, PH_DIGITS: begin
          if (cur_state.phase == PH_LETTER_OR_DIGIT && is_letter) begin
            upd.column_acc = col_two;
            upd.phase      = PH_DIGITS;
            upd.error_seen = (col_two >= max_cols);
          end else if (!is_digit) begin
            upd.error_seen = 1'b1;
          end else begin
            upd.phase = PH_DIGITS;
            if (row_next > {{(ROWMUL_W-ROW_W){1'b0}}, max_rows}) begin
              upd.error_seen = 1'b1;
            end else begin
              upd.row_acc = row_next[ROW_W-1:0];
            end
          end
        end
        default: begin
          upd = cur_state;
        end
      endcase
    end
  end

  always_comb begin
    result.name_ok = !upd.error_seen && (upd.phase != PH_FIRST) && (upd.row_acc != '0);
    if (result.name_ok) begin
      result.column_index = upd.column_acc;
      result.row_index    = upd.row_acc[ROWIX_W-1:0] - 16'd1;
    end else begin
      result.column_index = '0;
      result.row_index    = '0;
    end
  end

  // a reference ends with its last character: start afresh
  assign state_nxt = last_char ? STATE_CLEAR : upd;

endmodule

FILE: sv/cell_reference_parser_unit.sv
// Top level of the cell reference parser: state, limits and result buffering.
//
// Parses an A1-style cell reference (one or two letters of either case, then
// decimal row digits) one character per input transaction. The unit takes a
// character in every cycle in which in_stall is low; each character updates
// the parse state in a single pass of logic into the state registers. The
// character flagged last_char produces one result transaction, registered
// into the output or skid register as it is taken; the parse state is cleared
// for the next reference. A two-entry output buffer (output register plus one
// skid register) lets input continue while a result waits; in_stall rises
// only when both entries hold results, i.e. after two references have
// finished against a stalled output. Bad characters, a column at or above
// max_cols, a row above max_rows or a zero/missing row give name_ok = 0 with
// zero column and row. Limits are written through the cfg_ port and should
// only be changed while no reference is in flight.
module cell_reference_parser_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [crp_pkg::CFG_W-1:0]      cfg_wdata,
  // character input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [crp_pkg::CHAR_W-1:0]     in_char_code,
  input  logic                           in_last_char,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_name_ok,
  output logic [crp_pkg::COL_W-1:0]      out_column_index,
  output logic [crp_pkg::ROWIX_W-1:0]    out_row_index
);
  import crp_pkg::*;

  parse_state_t     state_r;
  parse_state_t     state_nxt;
  parse_state_t     step_state;
  parse_result_t    step_result;

  logic [COL_W-1:0] max_cols_r;
  logic [ROW_W-1:0] max_rows_r;

  logic             out_valid_r;
  logic             out_valid_nxt;
  parse_result_t    out_data_r;
  parse_result_t    out_data_nxt;
  logic             skid_valid_r;
  logic             skid_valid_nxt;
  parse_result_t    skid_data_r;
  parse_result_t    skid_data_nxt;

  logic             in_take;
  logic             res_new;
  logic             out_take;

  // --- configuration registers ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cols_r <= MAX_COLS_RST;
      max_rows_r <= MAX_ROWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MAX_COLS: max_cols_r <= cfg_wdata[COL_W-1:0];
        CFG_MAX_ROWS: max_rows_r <= cfg_wdata[ROW_W-1:0];
        default:      max_cols_r <= max_cols_r;
      endcase
    end
  end

  // --- handshakes ---
  assign in_stall = skid_valid_r;       // only stall once both entries are full
  assign in_take  = in_valid && !in_stall;
  assign res_new  = in_take && in_last_char;
  assign out_take = out_valid_r && !out_stall;

  // --- per-character parse step ---
  crp_step u_step (
    .cur_state (state_r),
    .char_code (in_char_code),
    .last_char (in_last_char),
    .max_cols  (max_cols_r),
    .max_rows  (max_rows_r),
    .state_nxt (step_state),
    .result    (step_result)
  );

  assign state_nxt = in_take ? step_state : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --- result buffer: output register with one skid entry behind it ---
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        // input is stalled here, so no new result competes
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (res_new) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = step_result;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (res_new) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = step_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_name_ok      = out_data_r.name_ok;
  assign out_column_index = out_data_r.column_index;
  assign out_row_index    = out_data_r.row_index;

endmodule

FILE: tb/crp_ref_checker.sv
// Result checker for the cell reference parser: mirrors the parse and compares results.
module crp_ref_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [crp_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [crp_pkg::CHAR_W-1:0]     in_char_code,
  input  logic                           in_last_char,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_name_ok,
  input  logic [crp_pkg::COL_W-1:0]      out_column_index,
  input  logic [crp_pkg::ROWIX_W-1:0]    out_row_index,
  output int                             fail_count,
  output int                             refs_pending
);
  import crp_pkg::*;

  localparam int unsigned DEC_BASE = 10;

  // mirrored limits and parse state
  logic [COL_W-1:0] col_limit;
  logic [ROW_W-1:0] row_limit;
  parse_phase_t     stage;
  logic [COL_W-1:0] col_val;
  logic [ROW_W-1:0] row_val;
  logic             faulted;

  parse_result_t expected_q[$];
  int            fails;

  task automatic clear_parse();
    stage   = PH_FIRST;
    col_val = '0;
    row_val = '0;
    faulted = 1'b0;
  endtask

  // one character into the mirrored parse
  task automatic absorb_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] up;
    int                letter;
    logic              digit;
    int unsigned       next_row;
    up     = (c >= CHAR_LO_A && c <= CHAR_LO_Z) ? c - CHAR_LO_A + CHAR_UP_A : c;
    letter = (up >= CHAR_UP_A && up <= CHAR_UP_Z) ? int'(up - CHAR_UP_A) : -1;
    digit  = (c >= CHAR_ZERO && c <= CHAR_NINE);
    if (faulted) return;
    if (stage == PH_FIRST) begin
      if (letter < 0) begin
        faulted = 1'b1;
      end else begin
        col_val = COL_W'(letter);
        stage   = PH_LETTER_OR_DIGIT;
        faulted = (col_val >= col_limit);
      end
    end else if (stage == PH_LETTER_OR_DIGIT && letter >= 0) begin
      col_val = (col_val + 1'b1) * ALPHA_COUNT + COL_W'(letter);
      stage   = PH_DIGITS;
      faulted = (col_val >= col_limit);
    end else if (!digit) begin
      faulted = 1'b1;
    end else begin
      stage    = PH_DIGITS;
      next_row = row_val * DEC_BASE + (c - CHAR_ZERO);
      // an over-limit digit leaves the row as it was
      if (next_row > row_limit) faulted = 1'b1;
      else row_val = ROW_W'(next_row);
    end
  endtask

  always @(posedge clk) begin
    parse_result_t want;
    logic          ok;
    if (!rst_n) begin
      col_limit = MAX_COLS_RST;
      row_limit = MAX_ROWS_RST;
      clear_parse();
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_MAX_COLS: col_limit = cfg_wdata[COL_W-1:0];
          CFG_MAX_ROWS: row_limit = cfg_wdata[ROW_W-1:0];
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: name_ok=%0d column_index=%0d row_index=%0d",
                 out_name_ok, out_column_index, out_row_index);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (out_name_ok !== want.name_ok) begin
            $error("name_ok: expected %0d, actual %0d", want.name_ok, out_name_ok);
            fails++;
          end
          if (out_column_index !== want.column_index) begin
            $error("column_index: expected %0d, actual %0d",
                   want.column_index, out_column_index);
            fails++;
          end
          if (out_row_index !== want.row_index) begin
            $error("row_index: expected %0d, actual %0d", want.row_index, out_row_index);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        absorb_char(in_char_code);
        if (in_last_char) begin
          ok = !faulted && stage != PH_FIRST && row_val != 0;
          want.name_ok      = ok;
          want.column_index = ok ? col_val : '0;
          want.row_index    = ok ? ROWIX_W'(row_val - 1'b1) : '0;
          expected_q.push_back(want);
          clear_parse();
        end
      end
    end
    refs_pending <= expected_q.size();
    fail_count   <= fails;
  end

endmodule

FILE: tb/tb_cell_reference_parser_unit.sv
// Testbench top for the cell reference parser: stimulus, flow control and verdict.
module tb_cell_reference_parser_unit;
  import crp_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RUN_LIMIT    = 500000;
  localparam int RANDOM_CHARS = 1700;
  localparam int PHASES       = 10;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_we       = 1'b0;
  cfg_index_t         cfg_sel      = CFG_MAX_COLS;
  logic [CFG_W-1:0]   cfg_wdata    = '0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [CHAR_W-1:0]  in_char_code = '0;
  logic               in_last_char = 1'b0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic               out_name_ok;
  logic [COL_W-1:0]   out_column_index;
  logic [ROWIX_W-1:0] out_row_index;

  int fail_count;
  int refs_pending;

  // limits currently programmed, used to aim the stimulus at the boundaries
  int unsigned cur_cols = MAX_COLS_RST;
  int unsigned cur_rows = MAX_ROWS_RST;
  // chance in percent that an idle burst starts; 0 switches idling off
  int          idle_rate = 0;
  int          stall_left = 0;
  int          chars_sent = 0;
  int          cycle_count = 0;

  // characters of the reference being built
  logic [CHAR_W-1:0] ref_q[$];

  always #(CLK_HALF) clk = ~clk;

  cell_reference_parser_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_sel),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_name_ok      (out_name_ok),
    .out_column_index (out_column_index),
    .out_row_index    (out_row_index)
  );

  crp_ref_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_sel),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_name_ok      (out_name_ok),
    .out_column_index (out_column_index),
    .out_row_index    (out_row_index),
    .fail_count       (fail_count),
    .refs_pending     (refs_pending)
  );

  // Result side back-pressure: stall bursts of random length, started at random.
  // Nothing here looks at out_valid, so stalls land on every phase of the work.
  always @(posedge clk) begin
    if (!rst_n || idle_rate == 0) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 99) < idle_rate) begin
      stall_left <= $urandom_range(0, 10);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One character transaction. An optional gap first; valid stays high between
  // back-to-back transactions and the payload holds while stalled.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    int gap;
    if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  // Send the built reference, last_char on its final character.
  task automatic send_ref();
    foreach (ref_q[i]) send_char(ref_q[i], i == ref_q.size() - 1);
    ref_q.delete();
  endtask

  // Limits change only with nothing in flight: the sender idles until every result is back.
  task automatic write_limit(input cfg_index_t idx, input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (refs_pending != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_sel   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(input logic [COL_W-1:0] cols, input logic [ROW_W-1:0] rows);
    logic [CFG_W-COL_W-1:0] junk;
    // bits above the column width are don't-care on a max_cols write
    junk = (CFG_W-COL_W)'($urandom_range(0, (1 << (CFG_W - COL_W)) - 1));
    write_limit(CFG_MAX_COLS, {junk, cols});
    write_limit(CFG_MAX_ROWS, rows);
    cur_cols = cols;
    cur_rows = rows;
  endtask

  // letter value 0..25 in either case
  task automatic push_letter(input logic [CHAR_W-1:0] v);
    ref_q.push_back(($urandom_range(0, 1) ? CHAR_LO_A : CHAR_UP_A) + v);
  endtask

  // decimal row, sometimes with leading zeros
  task automatic push_row(input int unsigned n);
    logic [CHAR_W-1:0] digits[$];
    int                zeros;
    zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
    repeat (zeros) ref_q.push_back(CHAR_ZERO);
    do begin
      digits.push_front(CHAR_ZERO + CHAR_W'(n % 10));
      n = n / 10;
    end while (n != 0);
    ref_q = {ref_q, digits};
  endtask

  // Mostly well-formed references aimed at the column and row limits; the
  // rest is raw byte noise or a good reference with one fault put in.
  task automatic make_reference();
    int unsigned pick, col, row, top_col, pos;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 6)) ref_q.push_back(CHAR_W'($urandom_range(0, 255)));
      return;
    end
    top_col = (cur_cols == 0) ? 0 : (cur_cols > 702) ? 701 : cur_cols - 1;
    case ($urandom_range(0, 9))
      0:       col = cur_cols;
      1:       col = top_col;
      2:       col = $urandom_range(0, 701);
      default: col = $urandom_range(0, top_col);
    endcase
    if (col > 701) col = 701;
    // one letter gives 0..25, two letters give 26..701
    if (col < 26) begin
      push_letter(CHAR_W'(col));
    end else begin
      push_letter(CHAR_W'(col / 26 - 1));
      push_letter(CHAR_W'(col % 26));
    end
    case ($urandom_range(0, 11))
      0:       row = cur_rows;
      1:       row = cur_rows + $urandom_range(1, 9);
      2:       row = 0;
      3:       row = $urandom_range(1, 20);
      4:       row = $urandom_range(1, cur_rows * 10);
      default: row = $urandom_range(1, cur_rows);
    endcase
    push_row(row);
    if (pick < 30) begin
      case ($urandom_range(0, 2))
        0: begin
          pos = $urandom_range(0, ref_q.size() - 1);
          ref_q[pos] = CHAR_W'($urandom_range(0, 255));
        end
        1: push_letter(CHAR_W'($urandom_range(0, 25)));
        default: begin
          // drop the row digits entirely
          while (ref_q.size() > 1 && ref_q[$] >= CHAR_ZERO && ref_q[$] <= CHAR_NINE)
            ref_q.pop_back();
        end
      endcase
    end
  endtask

  // Watchdog: a stuck handshake or a missing result ends the run here.
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("cell_reference_parser_unit: mismatch");
    $finish;
  end

  initial begin
    string       directed[8];
    int          stop_at;
    logic [9:0]  cols;
    logic [16:0] rows;
    // Directed part, reset limits (256 columns, 65536 rows): smallest and
    // largest legal reference, column at the limit, zero row, no digits,
    // digit first, letter after a digit, letter after two letters.
    directed = '{"a1", "iV65536", "IW1", "B0", "C", "9", "A9b", "xyz"};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_rate = 20;
    foreach (directed[d]) begin
      for (int i = 0; i < directed[d].len(); i++) ref_q.push_back(directed[d][i]);
      send_ref();
    end
    // NUL and a high byte count as bad characters
    ref_q.push_back(8'h00);
    send_ref();
    ref_q.push_back(CHAR_UP_A + 8'd16);
    ref_q.push_back(8'hFF);
    send_ref();

    // Random part in phases, each under its own limits. Early phases hit the
    // extremes: single row and column, a zero column limit (nothing passes),
    // a row limit above 16 bits, all column bits set.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cols = 10'd1;   rows = 17'd1;      end
        1: begin cols = 10'd702; rows = 17'd65536;  end
        2: begin cols = 10'd0;   rows = 17'd100;    end
        3: begin cols = 10'd27;  rows = 17'd131071; end
        4: begin cols = 10'd1023; rows = 17'd9;     end
        PHASES - 1: begin cols = MAX_COLS_RST; rows = MAX_ROWS_RST; end
        default: begin
          cols = COL_W'($urandom_range(1, 702));
          rows = $urandom_range(0, 1) ? ROW_W'($urandom_range(1, 999))
                                      : ROW_W'($urandom_range(1, 131071));
        end
      endcase
      set_limits(cols, rows);
      // some phases run flat out; the final one has no idling at all
      idle_rate = (p == PHASES - 1 || p % 3 == 2) ? 0 : $urandom_range(5, 35);
      stop_at = chars_sent + RANDOM_CHARS / PHASES;
      while (chars_sent < stop_at) begin
        make_reference();
        send_ref();
      end
    end

    // drain, then let the output buffer settle
    in_valid <= 1'b0;
    do @(posedge clk); while (refs_pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("cell_reference_parser_unit: match");
    end else begin
      $display("cell_reference_parser_unit: mismatch");
    end
    $finish;
  end

endmodule
